FILE: rtl/ctfu_pkg.sv
`timescale 1ns / 1ps
// ctfu_pkg: shared constants, register indexes and types of the trilinear upsampler
// no dependencies

package ctfu_pkg;

    localparam int MAX_COARSE_CELLS = 4096;
    localparam int CELL_AW          = $clog2(MAX_COARSE_CELLS);
    localparam int NFIELDS          = 5;
    localparam int DW               = 32;
    localparam int ROW_W            = NFIELDS * DW;
    localparam int ROWB_W           = 31;
    localparam int ADDR_W           = ROWB_W + 1;
    localparam int QDEPTH           = 2;
    localparam int QPTR_W           = 1;
    localparam int QCNT_W           = 2;

    // register indexes
    localparam logic [2:0] REG_STEP_X   = 3'd0;
    localparam logic [2:0] REG_STEP_Y   = 3'd1;
    localparam logic [2:0] REG_STEP_Z   = 3'd2;
    localparam logic [2:0] REG_ORIGIN_X = 3'd3;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd5;
    localparam logic [2:0] REG_DIMS     = 3'd6;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [30:0] step_x;
        logic [30:0] step_y;
        logic [30:0] step_z;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] origin_z;
        logic [29:0] dims;
    } cfg_t;

    typedef struct packed {
        logic                          cmd;
        logic [CELL_AW-1:0]            cell_index;
        logic [ROW_W-1:0]              row;
        logic [9:0]                    xlo;
        logic [9:0]                    xhi;
        logic [3:0][ROWB_W-1:0]        rowbase;
        logic [15:0]                   tx;
        logic [15:0]                   ty;
        logic [15:0]                   tz;
    } job_t;

endpackage

FILE: rtl/ctfu_if.sv
`timescale 1ns / 1ps
// ctfu_req_if / ctfu_rsp_if: valid-ready channels of the upsampler
// no dependencies

interface ctfu_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [11:0]        cell_index;
    logic signed [31:0] load_rho;
    logic signed [31:0] load_theta;
    logic signed [31:0] load_xvel;
    logic signed [31:0] load_yvel;
    logic signed [31:0] load_zvel;
    logic [9:0]         fine_i;
    logic [9:0]         fine_j;
    logic [9:0]         fine_k;

    modport source (output valid, cmd, cell_index, load_rho, load_theta, load_xvel,
                    load_yvel, load_zvel, fine_i, fine_j, fine_k, input ready);
    modport sink (input valid, cmd, cell_index, load_rho, load_theta, load_xvel,
                  load_yvel, load_zvel, fine_i, fine_j, fine_k, output ready);
endinterface

interface ctfu_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_rho;
    logic signed [31:0] out_theta;
    logic signed [31:0] out_xvel;
    logic signed [31:0] out_yvel;
    logic signed [31:0] out_zvel;

    modport source (output valid, out_rho, out_theta, out_xvel, out_yvel, out_zvel,
                    input ready);
    modport sink (input valid, out_rho, out_theta, out_xvel, out_yvel, out_zvel,
                  output ready);
endinterface

FILE: rtl/ctfu_front.sv
`timescale 1ns / 1ps
// ctfu_front: accepts words, works out corner indices, fractions and row bases
// depends on ctfu_pkg, ctfu_if

module ctfu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    ctfu_req_if.sink             req,
    input  ctfu_pkg::cfg_t       cfg,
    output ctfu_pkg::job_t       push_job,
    output logic                 push_valid,
    input  logic                 push_ready
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_POS   = 3'd1;
    localparam logic [2:0] F_CLAMP = 3'd2;
    localparam logic [2:0] F_ZMUL  = 3'd3;
    localparam logic [2:0] F_ROW   = 3'd4;
    localparam logic [2:0] F_PUSH  = 3'd5;

    logic [2:0]          ph_reg, ph_next;
    ctfu_pkg::job_t      job_reg;
    logic [9:0]          fi_reg, fj_reg, fk_reg;
    logic signed [42:0]  rx_reg, ry_reg, rz_reg;
    logic [9:0]          ylo_reg, yhi_reg, zlo_reg, zhi_reg;
    logic [19:0]         pz0_reg, pz1_reg;
    logic [9:0]          nx_eff, ny_eff, nz_eff;
    logic [9:0]          xlo_c, ylo_c, zlo_c;
    logic [20:0]         row_y0z0, row_y1z0, row_y0z1, row_y1z1;
    logic                accept;

    // coarse position origin + step*index, exact
    function automatic logic signed [42:0] pos(input logic [30:0] step,
                                               input logic [31:0] origin,
                                               input logic [9:0] idx);
        logic [40:0] prod;
        prod = {10'b0, step} * {31'b0, idx};
        return $signed({{11{origin[31]}}, origin}) + $signed({2'b0, prod});
    endfunction

    // floor clamped to the grid
    function automatic logic [9:0] clamp_lo(input logic signed [42:0] r,
                                            input logic [9:0] n);
        logic signed [26:0] fl;
        logic [9:0]         last;
        fl   = r[42:16];
        last = n - 10'd1;
        if (fl < 0)
            return 10'd0;
        else if (fl > $signed({17'b0, last}))
            return last;
        else
            return fl[9:0];
    endfunction

    function automatic logic [9:0] clamp_hi(input logic [9:0] lo, input logic [9:0] n);
        logic [9:0] last;
        last = n - 10'd1;
        return (lo == last) ? last : lo + 10'd1;
    endfunction

    // a zero size counts as one
    assign nx_eff = (cfg.dims[9:0] == 10'd0) ? 10'd1 : cfg.dims[9:0];
    assign ny_eff = (cfg.dims[19:10] == 10'd0) ? 10'd1 : cfg.dims[19:10];
    assign nz_eff = (cfg.dims[29:20] == 10'd0) ? 10'd1 : cfg.dims[29:20];

    assign xlo_c = clamp_lo(rx_reg, nx_eff);
    assign ylo_c = clamp_lo(ry_reg, ny_eff);
    assign zlo_c = clamp_lo(rz_reg, nz_eff);

    assign row_y0z0 = {11'b0, ylo_reg} + {1'b0, pz0_reg};
    assign row_y1z0 = {11'b0, yhi_reg} + {1'b0, pz0_reg};
    assign row_y0z1 = {11'b0, ylo_reg} + {1'b0, pz1_reg};
    assign row_y1z1 = {11'b0, yhi_reg} + {1'b0, pz1_reg};

    assign req.ready  = (ph_reg == F_IDLE);
    assign accept     = req.valid && req.ready;
    assign push_valid = (ph_reg == F_PUSH);
    assign push_job   = job_reg;

    always_comb
    begin
        ph_next = ph_reg;
        case (ph_reg)
            F_IDLE:
            begin
                if (accept)
                    ph_next = (req.cmd == ctfu_pkg::CMD_QUERY) ? F_POS : F_PUSH;
            end
            F_POS:   ph_next = F_CLAMP;
            F_CLAMP: ph_next = F_ZMUL;
            F_ZMUL:  ph_next = F_ROW;
            F_ROW:   ph_next = F_PUSH;
            F_PUSH:
            begin
                if (push_ready)
                    ph_next = F_IDLE;
            end
            default: ph_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_reg <= F_IDLE;
        else
            ph_reg <= ph_next;
    end

    always_ff @(posedge clk)
    begin
        case (ph_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    job_reg.cmd        <= req.cmd;
                    job_reg.cell_index <= req.cell_index;
                    job_reg.row        <= {req.load_zvel, req.load_yvel, req.load_xvel,
                                           req.load_theta, req.load_rho};
                    fi_reg <= req.fine_i;
                    fj_reg <= req.fine_j;
                    fk_reg <= req.fine_k;
                end
            end
            F_POS:
            begin
                rx_reg <= pos(cfg.step_x, cfg.origin_x, fi_reg);
                ry_reg <= pos(cfg.step_y, cfg.origin_y, fj_reg);
                rz_reg <= pos(cfg.step_z, cfg.origin_z, fk_reg);
            end
            F_CLAMP:
            begin
                job_reg.xlo <= xlo_c;
                job_reg.xhi <= clamp_hi(xlo_c, nx_eff);
                ylo_reg     <= ylo_c;
                yhi_reg     <= clamp_hi(ylo_c, ny_eff);
                zlo_reg     <= zlo_c;
                zhi_reg     <= clamp_hi(zlo_c, nz_eff);
                job_reg.tx  <= rx_reg[15:0];
                job_reg.ty  <= ry_reg[15:0];
                job_reg.tz  <= rz_reg[15:0];
            end
            F_ZMUL:
            begin
                pz0_reg <= {10'b0, ny_eff} * {10'b0, zlo_reg};
                pz1_reg <= {10'b0, ny_eff} * {10'b0, zhi_reg};
            end
            F_ROW:
            begin
                job_reg.rowbase[0] <= {21'b0, nx_eff} * {10'b0, row_y0z0};
                job_reg.rowbase[1] <= {21'b0, nx_eff} * {10'b0, row_y1z0};
                job_reg.rowbase[2] <= {21'b0, nx_eff} * {10'b0, row_y0z1};
                job_reg.rowbase[3] <= {21'b0, nx_eff} * {10'b0, row_y1z1};
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/ctfu_queue.sv
`timescale 1ns / 1ps
// ctfu_queue: short queue of jobs between front and back
// depends on ctfu_pkg

module ctfu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  ctfu_pkg::job_t  push_job,
    input  logic            push_valid,
    output logic            push_ready,
    output ctfu_pkg::job_t  pop_job,
    output logic            pop_valid,
    input  logic            pop_ready
);

    ctfu_pkg::job_t                  slot_reg [ctfu_pkg::QDEPTH];
    logic [ctfu_pkg::QPTR_W-1:0]     wp_reg, rp_reg;
    logic [ctfu_pkg::QCNT_W-1:0]     cnt_reg;
    logic                            do_push, do_pop;

    assign push_ready = (cnt_reg != ctfu_pkg::QCNT_W'(ctfu_pkg::QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_job    = slot_reg[rp_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wp_reg <= wp_reg + 1'b1;
            if (do_pop)
                rp_reg <= rp_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wp_reg] <= push_job;
    end

endmodule

FILE: rtl/ctfu_back.sv
`timescale 1ns / 1ps
// ctfu_back: coarse store, corner reads, trilinear blend and result register
// depends on ctfu_pkg, ctfu_if

module ctfu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ctfu_pkg::job_t  pop_job,
    input  logic            pop_valid,
    output logic            pop_ready,
    ctfu_rsp_if.source      rsp
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_READ  = 2'd1;
    localparam logic [1:0] B_BLEND = 2'd2;
    localparam logic [1:0] B_DONE  = 2'd3;

    localparam int DW = ctfu_pkg::DW;

    logic [ctfu_pkg::ROW_W-1:0]  mem [ctfu_pkg::MAX_COARSE_CELLS];
    logic [ctfu_pkg::ROW_W-1:0]  mem_q;

    logic [1:0]                  st_reg;
    ctfu_pkg::job_t              job_reg;
    logic [3:0]                  issue_reg;
    logic [2:0]                  cap_reg;
    logic                        pend_reg, oob_reg;
    logic [2:0]                  step_reg;
    logic [2:0]                  fld_reg;
    logic [ctfu_pkg::ROW_W-1:0]  c_reg [8];
    logic [DW-1:0]               xr_reg [4];
    logic [DW-1:0]               yr_reg [2];
    logic [DW-1:0]               res_reg [ctfu_pkg::NFIELDS];
    logic [DW-1:0]               out_reg [ctfu_pkg::NFIELDS];
    logic                        out_valid_reg;

    logic                        take, is_load, mem_we, rd_en, out_load;
    logic [2:0]                  q;
    logic [ctfu_pkg::ADDR_W-1:0] rd_addr;
    logic [DW-1:0]               a_v, b_v, c0_f, c1_f, blend_v;
    logic [15:0]                 t_v;
    logic signed [32:0]          diff;
    logic signed [49:0]          prod;

    assign pop_ready = (st_reg == B_IDLE);
    assign take      = pop_valid && pop_ready;
    assign is_load   = (pop_job.cmd == ctfu_pkg::CMD_LOAD);
    assign mem_we    = take && is_load;

    // corner q: bit0 x upper, bit1 y upper, bit2 z upper
    assign q       = issue_reg[2:0];
    assign rd_addr = {1'b0, job_reg.rowbase[q[2:1]]}
                   + {22'b0, (q[0] ? job_reg.xhi : job_reg.xlo)};
    assign rd_en   = (st_reg == B_READ) && !issue_reg[3];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[pop_job.cell_index] <= pop_job.row;
        if (rd_en)
            mem_q <= mem[rd_addr[ctfu_pkg::CELL_AW-1:0]];
    end

    // blend operands: corners, then x blends, then y blends
    assign c0_f = c_reg[0][fld_reg*DW +: DW];
    assign c1_f = c_reg[1][fld_reg*DW +: DW];

    always_comb
    begin
        if (step_reg < 3'd4)
        begin
            a_v = c0_f;
            b_v = c1_f;
            t_v = job_reg.tx;
        end
        else if (step_reg < 3'd6)
        begin
            a_v = xr_reg[0];
            b_v = xr_reg[1];
            t_v = job_reg.ty;
        end
        else
        begin
            a_v = yr_reg[0];
            b_v = yr_reg[1];
            t_v = job_reg.tz;
        end
    end

    // a + floor(((b-a)*t + half) / one); stays between a and b, so no overflow
    assign diff    = $signed({b_v[DW-1], b_v}) - $signed({a_v[DW-1], a_v});
    assign prod    = diff * $signed({1'b0, t_v}) + 50'sd32768;
    assign blend_v = a_v + prod[47:16];

    assign out_load = (st_reg == B_DONE) && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_IDLE;
            issue_reg     <= '0;
            cap_reg       <= '0;
            pend_reg      <= 1'b0;
            step_reg      <= '0;
            fld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            pend_reg <= rd_en;

            case (st_reg)
                B_IDLE:
                begin
                    if (take && !is_load)
                    begin
                        st_reg    <= B_READ;
                        issue_reg <= '0;
                        cap_reg   <= '0;
                    end
                end
                B_READ:
                begin
                    if (rd_en)
                        issue_reg <= issue_reg + 4'd1;
                    if (pend_reg)
                    begin
                        cap_reg <= cap_reg + 3'd1;
                        if (cap_reg == 3'd7)
                        begin
                            st_reg   <= B_BLEND;
                            step_reg <= '0;
                            fld_reg  <= '0;
                        end
                    end
                end
                B_BLEND:
                begin
                    if (step_reg == 3'd6)
                    begin
                        step_reg <= '0;
                        fld_reg  <= fld_reg + 3'd1;
                        if (fld_reg == 3'(ctfu_pkg::NFIELDS - 1))
                            st_reg <= B_DONE;
                    end
                    else
                        step_reg <= step_reg + 3'd1;
                end
                B_DONE:
                begin
                    if (out_load)
                        st_reg <= B_IDLE;
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !is_load)
            job_reg <= pop_job;
        if (rd_en)
            oob_reg <= (rd_addr[ctfu_pkg::ADDR_W-1:ctfu_pkg::CELL_AW] != '0);
        // corners arrive in order and shift in from the top
        if (st_reg == B_READ && pend_reg)
        begin
            for (int i = 0; i < 7; i++)
                c_reg[i] <= c_reg[i+1];
            c_reg[7] <= oob_reg ? '0 : mem_q;
        end
        if (st_reg == B_BLEND)
        begin
            if (step_reg < 3'd4)
            begin
                // rotate by one corner pair; four steps bring it back
                for (int i = 0; i < 8; i++)
                    c_reg[i] <= c_reg[(i + 2) % 8];
                for (int i = 0; i < 3; i++)
                    xr_reg[i] <= xr_reg[i+1];
                xr_reg[3] <= blend_v;
            end
            else if (step_reg < 3'd6)
            begin
                xr_reg[0] <= xr_reg[2];
                xr_reg[1] <= xr_reg[3];
                yr_reg[0] <= yr_reg[1];
                yr_reg[1] <= blend_v;
            end
            else
                res_reg[fld_reg] <= blend_v;
        end
        if (out_load)
            for (int i = 0; i < ctfu_pkg::NFIELDS; i++)
                out_reg[i] <= res_reg[i];
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_rho   = out_reg[0];
    assign rsp.out_theta = out_reg[1];
    assign rsp.out_xvel  = out_reg[2];
    assign rsp.out_yvel  = out_reg[3];
    assign rsp.out_zvel  = out_reg[4];

endmodule

FILE: rtl/coarse_to_fine_trilinear_upsampler_core.sv
`timescale 1ns / 1ps
// coarse_to_fine_trilinear_upsampler_core: top level, register file and wiring
// depends on ctfu_pkg, ctfu_if, ctfu_front, ctfu_queue, ctfu_back
//
//   channel   dir   handshake              payload
//   req       in    valid/ready            cmd, cell_index, load_*, fine_i/j/k
//   rsp       out   valid/ready            out_rho, out_theta, out_*vel
//   apb       in    psel/penable/pready    paddr, pwdata, prdata (7 regs at 4*i)
//
// load: the front pushes the word and the back writes it into the store;
// query: the front finds positions, clamps, z products and row bases; the back reads
// eight corners, blends x, y, z per field on one shared multiplier, writes the result
// the two-entry queue lets the front prepare the next word while the back works
// reset clears control and loads the register defaults; the store is not cleared
// a full result register stalls the back only at its final write

module coarse_to_fine_trilinear_upsampler_core (
    input  logic        clk,
    input  logic        rst_n,
    ctfu_req_if.sink    req,
    ctfu_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ctfu_pkg::cfg_t  cfg_reg;
    ctfu_pkg::job_t  push_job, pop_job;
    logic            push_valid, push_ready, pop_valid, pop_ready;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_x   <= 31'd65536;
            cfg_reg.step_y   <= 31'd65536;
            cfg_reg.step_z   <= 31'd65536;
            cfg_reg.origin_x <= 32'hFFFF8000;
            cfg_reg.origin_y <= 32'hFFFF8000;
            cfg_reg.origin_z <= 32'hFFFF8000;
            cfg_reg.dims     <= 30'd1049601;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                ctfu_pkg::REG_STEP_X:   cfg_reg.step_x   <= pwdata[30:0];
                ctfu_pkg::REG_STEP_Y:   cfg_reg.step_y   <= pwdata[30:0];
                ctfu_pkg::REG_STEP_Z:   cfg_reg.step_z   <= pwdata[30:0];
                ctfu_pkg::REG_ORIGIN_X: cfg_reg.origin_x <= pwdata;
                ctfu_pkg::REG_ORIGIN_Y: cfg_reg.origin_y <= pwdata;
                ctfu_pkg::REG_ORIGIN_Z: cfg_reg.origin_z <= pwdata;
                ctfu_pkg::REG_DIMS:     cfg_reg.dims     <= pwdata[29:0];
                default:
                begin
                end
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            ctfu_pkg::REG_STEP_X:   prdata = {1'b0, cfg_reg.step_x};
            ctfu_pkg::REG_STEP_Y:   prdata = {1'b0, cfg_reg.step_y};
            ctfu_pkg::REG_STEP_Z:   prdata = {1'b0, cfg_reg.step_z};
            ctfu_pkg::REG_ORIGIN_X: prdata = cfg_reg.origin_x;
            ctfu_pkg::REG_ORIGIN_Y: prdata = cfg_reg.origin_y;
            ctfu_pkg::REG_ORIGIN_Z: prdata = cfg_reg.origin_z;
            ctfu_pkg::REG_DIMS:     prdata = {2'b0, cfg_reg.dims};
            default:                prdata = 32'd0;
        endcase
    end

    // front: takes words, resolves corner indices and fractions
    ctfu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg_reg),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // decouples front and back
    ctfu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_job    (pop_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // back: store writes, corner reads, blends and result register
    ctfu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_job    (pop_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .rsp        (rsp)
    );

endmodule
